>>> design/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and codes for the linked buffer pool: field widths, operation
// and status codes, and the command and result words.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

  // field widths of the command and result words
  localparam int FUNC_W   = 2;
  localparam int PORT_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int FLAGS_W  = 8;
  localparam int STATUS_W = 2;
  localparam int LEFT_W   = 5;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_ENQ   = 2'd1,
    FN_DEQ   = 2'd2,
    FN_REL   = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  // one command word
  typedef struct packed {
    func_t               func;
    logic [PORT_W-1:0]   port;
    logic [SLOT_W-1:0]   slot;
    logic [FLAGS_W-1:0]  flags;
  } op_t;

  // one result word
  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [FLAGS_W-1:0]  flags;
    logic [LEFT_W-1:0]   left;
  } result_t;

endpackage

`default_nettype wire

>>> design/lbp_ram.sv
// ----------------------------------------------------------------------------
// lbp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wa,
  input  wire logic [WIDTH-1:0]  wd,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] ra,
  output logic      [WIDTH-1:0]  rd
);

  logic [WIDTH-1:0] mem [1 << ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read, write-first on an address match
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (wa == ra)) begin
        rd <= wd;
      end else begin
        rd <= mem[ra];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/lbp_ctrl.sv
// ----------------------------------------------------------------------------
// lbp_ctrl
// List control: per-port free list and output queue pointers, free counts,
// link tag bits, and the next-state logic for one operation per cycle.
// Also forms the link store read address for the word being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_ctrl #(
  parameter  int PORTS     = 4,
  parameter  int QUEUE_LEN = 16,
  localparam int PIW       = (PORTS > 1) ? $clog2(PORTS) : 1,
  localparam int SIW       = $clog2(QUEUE_LEN),
  localparam int LW        = $clog2(QUEUE_LEN + 1),
  localparam int AW        = PIW + SIW
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // word being accepted, for the read address
  input  wire lbp_pkg::func_t                cmd_func,
  input  wire logic [lbp_pkg::PORT_W-1:0]    cmd_port,
  output logic      [AW-1:0]                 rd_addr,
  // word at the execute stage
  input  wire lbp_pkg::op_t                  op,
  input  wire logic                          fire,
  input  wire logic [LW-1:0]                 link_q,
  input  wire logic [lbp_pkg::FLAGS_W-1:0]   flag_q,
  // link store write port
  output logic                               link_we,
  output logic      [AW-1:0]                 link_wa,
  output logic      [LW-1:0]                 link_wd,
  // flag store write port
  output logic                               flag_we,
  output logic      [AW-1:0]                 flag_wa,
  output logic      [lbp_pkg::FLAGS_W-1:0]   flag_wd,
  // result of the executed word
  output lbp_pkg::result_t                   res
);

  localparam int            DEPTH = 1 << AW;
  localparam logic [LW-1:0] NONE  = '1;
  localparam logic [LW-1:0] QLEN  = LW'(QUEUE_LEN);

  // per-port pointers and counts
  logic [LW-1:0] free_head [PORTS];
  logic [LW-1:0] free_head_next [PORTS];
  logic [LW-1:0] queue_head [PORTS];
  logic [LW-1:0] queue_head_next [PORTS];
  logic [LW-1:0] queue_tail [PORTS];
  logic [LW-1:0] queue_tail_next [PORTS];
  logic [LW-1:0] free_count [PORTS];
  logic [LW-1:0] free_count_next [PORTS];

  // link tags: nil marks a link cut to none, lval marks a written link
  logic [DEPTH-1:0] nil_bits;
  logic [DEPTH-1:0] nil_bits_next;
  logic [DEPTH-1:0] lval_bits;
  logic [DEPTH-1:0] lval_bits_next;

  logic [PIW-1:0] pidx;
  logic [PIW-1:0] cidx;
  logic [SIW-1:0] sidx;
  logic           port_ok;
  logic           slot_ok;
  logic [LW-1:0]  head_sel;
  logic [LW-1:0]  fwd_sel;
  logic [LW-1:0]  tail_cur;
  logic [AW-1:0]  cur_addr;
  logic [AW-1:0]  slot_addr;
  logic [AW-1:0]  tail_addr;
  logic [LW-1:0]  reset_link;
  logic [LW-1:0]  link_eff;

  function automatic logic is_none(input logic [LW-1:0] v);
    return v >= QLEN;
  endfunction

  // decode of the executing word
  assign pidx      = PIW'(op.port);
  assign sidx      = SIW'(op.slot);
  assign port_ok   = 32'(op.port) < PORTS;
  assign slot_ok   = 32'(op.slot) < QUEUE_LEN;
  assign head_sel  = (op.func == lbp_pkg::FN_ALLOC) ? free_head[pidx] : queue_head[pidx];
  assign tail_cur  = queue_tail[pidx];
  assign cur_addr  = {pidx, head_sel[SIW-1:0]};
  assign slot_addr = {pidx, sidx};
  assign tail_addr = {pidx, tail_cur[SIW-1:0]};

  // link of the head entry: cut, written, or still at its reset value
  always_comb begin
    if ((LW'(cur_addr[SIW-1:0]) + LW'(1)) < QLEN) begin
      reset_link = LW'(cur_addr[SIW-1:0]) + LW'(1);
    end else begin
      reset_link = NONE;
    end
    if (nil_bits[cur_addr]) begin
      link_eff = NONE;
    end else if (lval_bits[cur_addr]) begin
      link_eff = link_q;
    end else begin
      link_eff = reset_link;
    end
  end

  // next state, store writes and result
  always_comb begin
    for (int p = 0; p < PORTS; p++) begin
      free_head_next[p]  = free_head[p];
      queue_head_next[p] = queue_head[p];
      queue_tail_next[p] = queue_tail[p];
      free_count_next[p] = free_count[p];
    end
    nil_bits_next  = nil_bits;
    lval_bits_next = lval_bits;
    link_we        = 1'b0;
    link_wa        = slot_addr;
    link_wd        = free_head[pidx];
    flag_we        = 1'b0;
    flag_wa        = slot_addr;
    flag_wd        = op.flags;
    res.status     = lbp_pkg::ST_DONE;
    res.slot       = '0;
    res.flags      = '0;
    res.left       = '0;

    if (fire && port_ok) begin
      unique case (op.func)
        lbp_pkg::FN_ALLOC: begin
          if (is_none(head_sel)) begin
            res.status = lbp_pkg::ST_NO_FREE;
          end else begin
            free_head_next[pidx] = link_eff;
            if (free_count[pidx] != '0) begin
              free_count_next[pidx] = free_count[pidx] - LW'(1);
            end
            res.slot = lbp_pkg::SLOT_W'(head_sel);
          end
        end
        lbp_pkg::FN_ENQ: begin
          if (slot_ok) begin
            nil_bits_next[slot_addr] = 1'b1;
            flag_we                  = 1'b1;
            queue_tail_next[pidx]    = LW'(sidx);
            if (is_none(tail_cur)) begin
              queue_head_next[pidx] = LW'(sidx);
            end else begin
              // old tail now links to the new slot
              link_we                   = 1'b1;
              link_wa                   = tail_addr;
              link_wd                   = LW'(sidx);
              nil_bits_next[tail_addr]  = 1'b0;
              lval_bits_next[tail_addr] = 1'b1;
            end
          end
        end
        lbp_pkg::FN_DEQ: begin
          if (is_none(head_sel)) begin
            res.status = lbp_pkg::ST_EMPTY;
          end else begin
            queue_head_next[pidx] = link_eff;
            if (is_none(link_eff)) begin
              queue_tail_next[pidx] = NONE;
            end
            res.slot  = lbp_pkg::SLOT_W'(head_sel);
            res.flags = flag_q;
          end
        end
        lbp_pkg::FN_REL: begin
          if (slot_ok) begin
            link_we                   = 1'b1;
            nil_bits_next[slot_addr]  = 1'b0;
            lval_bits_next[slot_addr] = 1'b1;
            free_head_next[pidx]      = LW'(sidx);
            if (free_count[pidx] < QLEN) begin
              free_count_next[pidx] = free_count[pidx] + LW'(1);
            end
          end
        end
      endcase
      res.left = lbp_pkg::LEFT_W'(free_count_next[pidx]);
    end
  end

  // read address of the accepted word, forwarded from this cycle's update
  assign cidx    = PIW'(cmd_port);
  assign fwd_sel = (cmd_func == lbp_pkg::FN_ALLOC) ? free_head_next[cidx]
                                                   : queue_head_next[cidx];
  assign rd_addr = {cidx, fwd_sel[SIW-1:0]};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PORTS; p++) begin
        free_head[p]  <= '0;
        queue_head[p] <= NONE;
        queue_tail[p] <= NONE;
        free_count[p] <= QLEN;
      end
      nil_bits  <= '0;
      lval_bits <= '0;
    end else begin
      for (int p = 0; p < PORTS; p++) begin
        free_head[p]  <= free_head_next[p];
        queue_head[p] <= queue_head_next[p];
        queue_tail[p] <= queue_tail_next[p];
        free_count[p] <= free_count_next[p];
      end
      nil_bits  <= nil_bits_next;
      lval_bits <= lval_bits_next;
    end
  end

  // a granted or popped slot always comes with status done
  ap_grant_done: assert property (@(posedge clk) disable iff (rst)
    (fire && res.slot != '0) |-> (res.status == lbp_pkg::ST_DONE))
    else $error("slot reported with a failure status");

  // an empty dequeue never reports flags and never writes a link
  ap_empty_no_flags: assert property (@(posedge clk) disable iff (rst)
    (fire && res.status == lbp_pkg::ST_EMPTY) |-> (res.flags == '0 && !link_we))
    else $error("empty dequeue changed links or reported flags");

  // stores are written only by an executing word
  ap_write_on_fire: assert property (@(posedge clk) disable iff (rst)
    (link_we || flag_we) |-> fire)
    else $error("store written without an executing word");

endmodule

`default_nettype wire

>>> design/linked_buffer_pool_fifo_unit.sv
// ----------------------------------------------------------------------------
// linked_buffer_pool_fifo_unit
// Per-port buffer slot manager: a LIFO free list and a FIFO output queue
// threaded through one shared link store, one operation per command word.
// ----------------------------------------------------------------------------
//
//   channel   handshake              fields
//   -------   --------------------   ----------------------------------------
//   cmd       cmd_valid / cmd_stall  func, port, slot_in, flags_in
//   res       res_valid / res_stall  status, slot_out, flags_out, free_left
//
// One word per cycle sustained while res_stall is low; a taken command word
// goes to the execute stage with its link store read, then into the result reg.
// The link store read for the next word is addressed from the pointer values
// the executing word leaves, so back-to-back words on one port chain fully.
// Reset sets all pointers, counts and link tags.
// res_stall holds the result register and the execute stage; cmd_stall rises
// only while the execute stage is full and cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_buffer_pool_fifo_unit #(
  parameter int PORTS     = 4,
  parameter int QUEUE_LEN = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command channel
  input  wire logic                          cmd_valid,
  output logic                               cmd_stall,
  input  wire logic [lbp_pkg::FUNC_W-1:0]    func,
  input  wire logic [lbp_pkg::PORT_W-1:0]    port,
  input  wire logic [lbp_pkg::SLOT_W-1:0]    slot_in,
  input  wire logic [lbp_pkg::FLAGS_W-1:0]   flags_in,
  // result channel
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic      [lbp_pkg::STATUS_W-1:0]  status,
  output logic      [lbp_pkg::SLOT_W-1:0]    slot_out,
  output logic      [lbp_pkg::FLAGS_W-1:0]   flags_out,
  output logic      [lbp_pkg::LEFT_W-1:0]    free_left
);

  localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int SIW = $clog2(QUEUE_LEN);
  localparam int LW  = $clog2(QUEUE_LEN + 1);
  localparam int AW  = PIW + SIW;

  lbp_pkg::op_t     cmd_op;
  lbp_pkg::op_t     ex_op;
  lbp_pkg::result_t ex_res;
  lbp_pkg::result_t res_q;

  logic                        cmd_acc;
  logic                        ex_valid;
  logic                        ex_fire;
  logic [AW-1:0]               rd_addr;
  logic [LW-1:0]               link_q;
  logic [lbp_pkg::FLAGS_W-1:0] flag_q;
  logic                        link_we;
  logic [AW-1:0]               link_wa;
  logic [LW-1:0]               link_wd;
  logic                        flag_we;
  logic [AW-1:0]               flag_wa;
  logic [lbp_pkg::FLAGS_W-1:0] flag_wd;

  // command word and handshake
  assign cmd_op.func  = lbp_pkg::func_t'(func);
  assign cmd_op.port  = port;
  assign cmd_op.slot  = slot_in;
  assign cmd_op.flags = flags_in;

  assign ex_fire   = ex_valid && (!res_valid || !res_stall);
  assign cmd_stall = ex_valid && !ex_fire;
  assign cmd_acc   = cmd_valid && !cmd_stall;

  // execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (cmd_acc) begin
      ex_valid <= 1'b1;
    end else if (ex_fire) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      ex_op <= cmd_op;
    end
  end

  // link and flag stores, read as the word is taken
  lbp_ram #(
    .WIDTH  (LW),
    .ADDR_W (AW)
  ) u_link_ram (
    .clk (clk),
    .we  (link_we),
    .wa  (link_wa),
    .wd  (link_wd),
    .re  (cmd_acc),
    .ra  (rd_addr),
    .rd  (link_q)
  );

  lbp_ram #(
    .WIDTH  (lbp_pkg::FLAGS_W),
    .ADDR_W (AW)
  ) u_flag_ram (
    .clk (clk),
    .we  (flag_we),
    .wa  (flag_wa),
    .wd  (flag_wd),
    .re  (cmd_acc),
    .ra  (rd_addr),
    .rd  (flag_q)
  );

  // list control
  lbp_ctrl #(
    .PORTS     (PORTS),
    .QUEUE_LEN (QUEUE_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_func (cmd_op.func),
    .cmd_port (port),
    .rd_addr  (rd_addr),
    .op       (ex_op),
    .fire     (ex_fire),
    .link_q   (link_q),
    .flag_q   (flag_q),
    .link_we  (link_we),
    .link_wa  (link_wa),
    .link_wd  (link_wd),
    .flag_we  (flag_we),
    .flag_wa  (flag_wa),
    .flag_wd  (flag_wd),
    .res      (ex_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ex_fire) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      res_q <= ex_res;
    end
  end

  assign status    = res_q.status;
  assign slot_out  = res_q.slot;
  assign flags_out = res_q.flags;
  assign free_left = res_q.left;

  // the command side stalls only behind a held execute stage
  ap_stall_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (ex_valid && res_valid && res_stall))
    else $error("command stalled with room to move");

  // an executed word always lands in the result register
  ap_fire_loads: assert property (@(posedge clk) disable iff (rst)
    ex_fire |=> res_valid)
    else $error("executed word lost");

  // a taken command word is at the execute stage next cycle
  ap_accept_fills: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> ex_valid)
    else $error("accepted word lost");

  // failure results carry no slot and no flags
  ap_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status == lbp_pkg::ST_NO_FREE || status == lbp_pkg::ST_EMPTY))
      |-> (slot_out == '0 && flags_out == '0))
    else $error("failure result carries a slot");

endmodule

`default_nettype wire
